@@ design/rihv_pkg.sv @@
// Shared types, header offsets and size-code tables for the ROM image header validator.
package rihv_pkg;

	// Header byte offsets within the image
	localparam int unsigned HDR_ADDR_BITS = 9;
	localparam logic [HDR_ADDR_BITS-1:0] HDR_FIRST   = 9'h134;
	localparam logic [HDR_ADDR_BITS-1:0] HDR_LAST    = 9'h14C;
	localparam logic [HDR_ADDR_BITS-1:0] POS_TYPE    = 9'h147;
	localparam logic [HDR_ADDR_BITS-1:0] POS_ROMSZ   = 9'h148;
	localparam logic [HDR_ADDR_BITS-1:0] POS_RAMSZ   = 9'h149;
	localparam logic [HDR_ADDR_BITS-1:0] POS_HSUM    = 9'h14D;
	localparam logic [HDR_ADDR_BITS-1:0] POS_GSUM_HI = 9'h14E;
	localparam logic [HDR_ADDR_BITS-1:0] POS_GSUM_LO = 9'h14F;

	// Only ROM-only cartridges are supported
	localparam logic [7:0] TYPE_ROM_ONLY = 8'h00;

	// Field widths
	localparam int unsigned ROM_BANK_BITS = 10;
	localparam int unsigned RAM_BANK_BITS = 5;

	// ROM size codes
	localparam logic [7:0] ROM_CODE_SHIFT_MAX = 8'h08;
	localparam logic [7:0] ROM_CODE_72        = 8'h52;
	localparam logic [7:0] ROM_CODE_80        = 8'h53;
	localparam logic [7:0] ROM_CODE_96        = 8'h54;
	localparam int unsigned ROM_BANK_KIB = 16;
	localparam logic [ROM_BANK_BITS-1:0] ROM_BANKS_72 = ROM_BANK_BITS'(1152 / ROM_BANK_KIB);
	localparam logic [ROM_BANK_BITS-1:0] ROM_BANKS_80 = ROM_BANK_BITS'(1280 / ROM_BANK_KIB);
	localparam logic [ROM_BANK_BITS-1:0] ROM_BANKS_96 = ROM_BANK_BITS'(1536 / ROM_BANK_KIB);

	// RAM size codes
	localparam logic [7:0] RAM_CODE_NONE  = 8'h00;
	localparam logic [7:0] RAM_CODE_2K    = 8'h01;
	localparam logic [7:0] RAM_CODE_8K    = 8'h02;
	localparam logic [7:0] RAM_CODE_32K   = 8'h03;
	localparam logic [7:0] RAM_CODE_128K  = 8'h04;
	localparam logic [7:0] RAM_CODE_64K   = 8'h05;
	localparam int unsigned RAM_BANK_KIB = 8;
	localparam logic [RAM_BANK_BITS-1:0] RAM_BANKS_2K   = RAM_BANK_BITS'(2 / RAM_BANK_KIB);
	localparam logic [RAM_BANK_BITS-1:0] RAM_BANKS_8K   = RAM_BANK_BITS'(8 / RAM_BANK_KIB);
	localparam logic [RAM_BANK_BITS-1:0] RAM_BANKS_32K  = RAM_BANK_BITS'(32 / RAM_BANK_KIB);
	localparam logic [RAM_BANK_BITS-1:0] RAM_BANKS_128K = RAM_BANK_BITS'(128 / RAM_BANK_KIB);
	localparam logic [RAM_BANK_BITS-1:0] RAM_BANKS_64K  = RAM_BANK_BITS'(64 / RAM_BANK_KIB);

	// Result status, checked in load order
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_HDR_BAD  = 2'd1,
		STATUS_TYPE_BAD = 2'd2,
		STATUS_GLB_BAD  = 2'd3
	} status_t;

	// Size code decode result
	typedef struct packed {
		logic [ROM_BANK_BITS-1:0] rom_banks;
		logic [RAM_BANK_BITS-1:0] ram_banks;
		logic                     rom_valid;
		logic                     ram_valid;
	} size_info_t;

	// ROM and RAM size code decode
	function automatic size_info_t decode_sizes(input logic [7:0] rom_code,
		input logic [7:0] ram_code);
		size_info_t info;
		info = '0;
		if (rom_code <= ROM_CODE_SHIFT_MAX) begin
			info.rom_banks = ROM_BANK_BITS'(2) << rom_code[3:0];
			info.rom_valid = 1'b1;
		end else begin
			unique case (rom_code)
				ROM_CODE_72: begin
					info.rom_banks = ROM_BANKS_72;
					info.rom_valid = 1'b1;
				end
				ROM_CODE_80: begin
					info.rom_banks = ROM_BANKS_80;
					info.rom_valid = 1'b1;
				end
				ROM_CODE_96: begin
					info.rom_banks = ROM_BANKS_96;
					info.rom_valid = 1'b1;
				end
				default: begin
					info.rom_banks = '0;
					info.rom_valid = 1'b0;
				end
			endcase
		end
		unique case (ram_code)
			RAM_CODE_NONE: begin
				info.ram_banks = '0;
				info.ram_valid = 1'b1;
			end
			RAM_CODE_2K: begin
				info.ram_banks = RAM_BANKS_2K;
				info.ram_valid = 1'b1;
			end
			RAM_CODE_8K: begin
				info.ram_banks = RAM_BANKS_8K;
				info.ram_valid = 1'b1;
			end
			RAM_CODE_32K: begin
				info.ram_banks = RAM_BANKS_32K;
				info.ram_valid = 1'b1;
			end
			RAM_CODE_128K: begin
				info.ram_banks = RAM_BANKS_128K;
				info.ram_valid = 1'b1;
			end
			RAM_CODE_64K: begin
				info.ram_banks = RAM_BANKS_64K;
				info.ram_valid = 1'b1;
			end
			default: begin
				info.ram_banks = '0;
				info.ram_valid = 1'b0;
			end
		endcase
		return info;
	endfunction

endpackage

@@ design/rom_image_header_validator.sv @@
// Top level of the ROM image header validator: byte stream in, one status word per image out.
// Streams a cartridge ROM image one byte per cycle while the input is not stalled, each byte
// with its offset, and keeps the 8-bit header checksum (0x134..0x14C) and the 16-bit global
// sum. It captures the type byte, the ROM/RAM size codes and both stored checksums, and on the
// word marked last_byte emits one result word: status (header sum, then type, then global sum;
// first failure wins), the computed sums, the type byte and the decoded bank counts. Throughput
// is one byte per cycle unless stalled: a byte sits in the input register while the sums and
// captures update, and when a last byte advances its result lands in the output register and
// out_valid rises. The input stalls only when a last byte is waiting and the output register
// still holds an untaken result.
// Captured header fields are kept across images; the running sums clear after each last byte.
module rom_image_header_validator #(
	parameter int unsigned ADDR_BITS = 23
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Byte input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rom_byte,
	input  logic [ADDR_BITS-1:0] byte_address,
	input  logic                 last_byte,
	// Result output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [7:0]           computed_header_sum,
	output logic [15:0]          computed_global_sum,
	output logic [7:0]           cart_type_code,
	output logic [rihv_pkg::ROM_BANK_BITS-1:0] rom_banks,
	output logic [rihv_pkg::RAM_BANK_BITS-1:0] ram_banks,
	output logic                 rom_code_valid,
	output logic                 ram_code_valid
);

	// Header offsets at the address width
	localparam logic [ADDR_BITS-1:0] A_HDR_FIRST = ADDR_BITS'(rihv_pkg::HDR_FIRST);
	localparam logic [ADDR_BITS-1:0] A_HDR_LAST  = ADDR_BITS'(rihv_pkg::HDR_LAST);
	localparam logic [ADDR_BITS-1:0] A_TYPE      = ADDR_BITS'(rihv_pkg::POS_TYPE);
	localparam logic [ADDR_BITS-1:0] A_ROMSZ     = ADDR_BITS'(rihv_pkg::POS_ROMSZ);
	localparam logic [ADDR_BITS-1:0] A_RAMSZ     = ADDR_BITS'(rihv_pkg::POS_RAMSZ);
	localparam logic [ADDR_BITS-1:0] A_HSUM      = ADDR_BITS'(rihv_pkg::POS_HSUM);
	localparam logic [ADDR_BITS-1:0] A_GSUM_HI   = ADDR_BITS'(rihv_pkg::POS_GSUM_HI);
	localparam logic [ADDR_BITS-1:0] A_GSUM_LO   = ADDR_BITS'(rihv_pkg::POS_GSUM_LO);

	// Input register
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic                 last_s1;

	// Running and captured state
	logic [7:0]  hdr_sum_q;
	logic [15:0] glb_sum_q;
	logic [7:0]  stored_hsum_q;
	logic [15:0] stored_gsum_q;
	logic [7:0]  type_q;
	logic [7:0]  rom_code_q;
	logic [7:0]  ram_code_q;

	// Output register
	logic                    out_valid_q;
	rihv_pkg::status_t       status_q;
	logic [7:0]              hdr_out_q;
	logic [15:0]             glb_out_q;
	logic [7:0]              type_out_q;
	rihv_pkg::size_info_t    size_q;

	// Next-state values with the byte in the input register applied
	logic                 adv_s1;
	logic                 fire_last;
	logic [7:0]           hdr_sum_nxt;
	logic [15:0]          glb_sum_nxt;
	logic [7:0]           stored_hsum_nxt;
	logic [15:0]          stored_gsum_nxt;
	logic [7:0]           type_nxt;
	logic [7:0]           rom_code_nxt;
	logic [7:0]           ram_code_nxt;
	logic [15:0]          gsum_adj;
	rihv_pkg::status_t    status_nxt;
	rihv_pkg::size_info_t size_nxt;

	// Only a last byte can be held back by a full output register
	assign adv_s1    = !(valid_s1 && last_s1 && out_valid_q && out_stall);
	assign fire_last = valid_s1 && last_s1 && adv_s1;
	assign in_stall  = valid_s1 && !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rom_byte;
			addr_s1 <= byte_address;
			last_s1 <= last_byte;
		end
	end

	// Sums and header captures for the byte in the input register
	always_comb begin
		hdr_sum_nxt     = hdr_sum_q;
		glb_sum_nxt     = glb_sum_q + {8'h00, byte_s1};
		stored_hsum_nxt = stored_hsum_q;
		stored_gsum_nxt = stored_gsum_q;
		type_nxt        = type_q;
		rom_code_nxt    = rom_code_q;
		ram_code_nxt    = ram_code_q;
		if (addr_s1 >= A_HDR_FIRST && addr_s1 <= A_HDR_LAST) begin
			hdr_sum_nxt = hdr_sum_q - (byte_s1 + 8'd1);
		end
		if (addr_s1 == A_TYPE) begin
			type_nxt = byte_s1;
		end
		if (addr_s1 == A_ROMSZ) begin
			rom_code_nxt = byte_s1;
		end
		if (addr_s1 == A_RAMSZ) begin
			ram_code_nxt = byte_s1;
		end
		if (addr_s1 == A_HSUM) begin
			stored_hsum_nxt = byte_s1;
		end
		if (addr_s1 == A_GSUM_HI) begin
			stored_gsum_nxt[15:8] = byte_s1;
		end
		if (addr_s1 == A_GSUM_LO) begin
			stored_gsum_nxt[7:0] = byte_s1;
		end
	end

	// Result word: global sum excludes the two stored checksum bytes
	always_comb begin
		gsum_adj = glb_sum_nxt - {8'h00, stored_gsum_nxt[15:8]} - {8'h00, stored_gsum_nxt[7:0]};
		if (hdr_sum_nxt != stored_hsum_nxt) begin
			status_nxt = rihv_pkg::STATUS_HDR_BAD;
		end else if (type_nxt != rihv_pkg::TYPE_ROM_ONLY) begin
			status_nxt = rihv_pkg::STATUS_TYPE_BAD;
		end else if (gsum_adj != stored_gsum_nxt) begin
			status_nxt = rihv_pkg::STATUS_GLB_BAD;
		end else begin
			status_nxt = rihv_pkg::STATUS_OK;
		end
		size_nxt = rihv_pkg::decode_sizes(rom_code_nxt, ram_code_nxt);
	end

	// State update; running sums clear after each image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_sum_q     <= '0;
			glb_sum_q     <= '0;
			stored_hsum_q <= '0;
			stored_gsum_q <= '0;
			type_q        <= '0;
			rom_code_q    <= '0;
			ram_code_q    <= '0;
		end else if (valid_s1 && adv_s1) begin
			hdr_sum_q     <= last_s1 ? 8'h00 : hdr_sum_nxt;
			glb_sum_q     <= last_s1 ? 16'h0000 : glb_sum_nxt;
			stored_hsum_q <= stored_hsum_nxt;
			stored_gsum_q <= stored_gsum_nxt;
			type_q        <= type_nxt;
			rom_code_q    <= rom_code_nxt;
			ram_code_q    <= ram_code_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_last) begin
			status_q   <= status_nxt;
			hdr_out_q  <= hdr_sum_nxt;
			glb_out_q  <= gsum_adj;
			type_out_q <= type_nxt;
			size_q     <= size_nxt;
		end
	end

	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign computed_header_sum = hdr_out_q;
	assign computed_global_sum = glb_out_q;
	assign cart_type_code      = type_out_q;
	assign rom_banks           = size_q.rom_banks;
	assign ram_banks           = size_q.ram_banks;
	assign rom_code_valid      = size_q.rom_valid;
	assign ram_code_valid      = size_q.ram_valid;

	// A stall on the input only comes from a last byte blocked by an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked last byte");

	// Running sums restart at zero after each image
	a_sums_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire_last |=> (hdr_sum_q == 8'h00 && glb_sum_q == 16'h0000))
		else $error("running sums not cleared after last byte");

	// A new result only follows a last byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a last byte");

endmodule

@@ tb/rihv_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the ROM image header validator: predicts each status word and compares it.
module rihv_checker #(
	parameter int unsigned AW = 23
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [7:0]                          rom_byte,
	input  logic [AW-1:0]                       byte_address,
	input  logic                                last_byte,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [1:0]                          status,
	input  logic [7:0]                          computed_header_sum,
	input  logic [15:0]                         computed_global_sum,
	input  logic [7:0]                          cart_type_code,
	input  logic [rihv_pkg::ROM_BANK_BITS-1:0] rom_banks,
	input  logic [rihv_pkg::RAM_BANK_BITS-1:0] ram_banks,
	input  logic                                rom_code_valid,
	input  logic                                ram_code_valid,
	output int                                  fail_count,
	output int                                  pending_count
);

	localparam int unsigned RB = rihv_pkg::ROM_BANK_BITS;
	localparam int unsigned MB = rihv_pkg::RAM_BANK_BITS;

	typedef struct packed {
		rihv_pkg::status_t st;
		logic [7:0]        hdr_sum;
		logic [15:0]       glb_sum;
		logic [7:0]        type_val;
		logic [RB-1:0]     rom_cnt;
		logic [MB-1:0]     ram_cnt;
		logic              rom_ok;
		logic              ram_ok;
	} image_report_t;

	// Status words owed by the block, oldest first
	image_report_t reports_due[$];
	image_report_t want;

	// Shadow copy of the block's sums and captured header fields
	logic [7:0]  hdr_acc;
	logic [15:0] glb_acc;
	logic [7:0]  stored_hdr;
	logic [15:0] stored_glb;
	logic [7:0]  type_byte;
	logic [7:0]  rom_code;
	logic [7:0]  ram_code;
	int          mismatches = 0;

	// 16 KiB banks for a ROM size code
	function automatic logic [RB-1:0] rom_bank_count(input logic [7:0] code,
		output logic known);
		known = 1'b1;
		if (code <= rihv_pkg::ROM_CODE_SHIFT_MAX)
			return RB'(2) << code;
		case (code)
			rihv_pkg::ROM_CODE_72: return RB'(1152 / 16);
			rihv_pkg::ROM_CODE_80: return RB'(1280 / 16);
			rihv_pkg::ROM_CODE_96: return RB'(1536 / 16);
			default: ;
		endcase
		known = 1'b0;
		return '0;
	endfunction

	// 8 KiB banks for a RAM size code; the 2 KiB part rounds down to none
	function automatic logic [MB-1:0] ram_bank_count(input logic [7:0] code,
		output logic known);
		known = 1'b1;
		case (code) inside
			rihv_pkg::RAM_CODE_NONE, rihv_pkg::RAM_CODE_2K: return '0;
			rihv_pkg::RAM_CODE_8K:   return MB'(1);
			rihv_pkg::RAM_CODE_32K:  return MB'(4);
			rihv_pkg::RAM_CODE_128K: return MB'(16);
			rihv_pkg::RAM_CODE_64K:  return MB'(8);
			default: ;
		endcase
		known = 1'b0;
		return '0;
	endfunction

	// Fold one accepted word into the sums and captures; a last byte closes the image
	task automatic absorb_byte(input logic [7:0] b, input logic [AW-1:0] a, input logic l);
		image_report_t r;
		logic [15:0]   gsum;
		if (a >= rihv_pkg::HDR_FIRST && a <= rihv_pkg::HDR_LAST)
			hdr_acc = hdr_acc - b - 8'd1;
		glb_acc = glb_acc + 16'(b);
		case (a)
			rihv_pkg::POS_TYPE:    type_byte = b;
			rihv_pkg::POS_ROMSZ:   rom_code = b;
			rihv_pkg::POS_RAMSZ:   ram_code = b;
			rihv_pkg::POS_HSUM:    stored_hdr = b;
			rihv_pkg::POS_GSUM_HI: stored_glb[15:8] = b;
			rihv_pkg::POS_GSUM_LO: stored_glb[7:0] = b;
			default: ;
		endcase
		if (l) begin
			// stored checksum bytes do not count toward the global sum
			gsum = glb_acc - 16'(stored_glb[15:8]) - 16'(stored_glb[7:0]);
			if (hdr_acc != stored_hdr)
				r.st = rihv_pkg::STATUS_HDR_BAD;
			else if (type_byte != rihv_pkg::TYPE_ROM_ONLY)
				r.st = rihv_pkg::STATUS_TYPE_BAD;
			else if (gsum != stored_glb)
				r.st = rihv_pkg::STATUS_GLB_BAD;
			else
				r.st = rihv_pkg::STATUS_OK;
			r.hdr_sum = hdr_acc;
			r.glb_sum = gsum;
			r.type_val = type_byte;
			r.rom_cnt = rom_bank_count(rom_code, r.rom_ok);
			r.ram_cnt = ram_bank_count(ram_code, r.ram_ok);
			reports_due.push_back(r);
			hdr_acc = '0;
			glb_acc = '0;
		end
	endtask

	// Watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_acc = '0;
			glb_acc = '0;
			stored_hdr = '0;
			stored_glb = '0;
			type_byte = '0;
			rom_code = '0;
			ram_code = '0;
			reports_due.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected status word: st=%0d hs=%02h gs=%04h ty=%02h",
							status, computed_header_sum, computed_global_sum, cart_type_code);
				end else begin
					want = reports_due.pop_front();
					if (status != want.st || computed_header_sum != want.hdr_sum ||
						computed_global_sum != want.glb_sum || cart_type_code != want.type_val ||
						rom_banks != want.rom_cnt || ram_banks != want.ram_cnt ||
						rom_code_valid != want.rom_ok || ram_code_valid != want.ram_ok) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch exp: st=%0d hs=%02h gs=%04h ty=%02h ",
								want.st, want.hdr_sum, want.glb_sum, want.type_val,
								"rb=%0d mb=%0d rv=%0b mv=%0b",
								want.rom_cnt, want.ram_cnt, want.rom_ok, want.ram_ok);
							$display("         got: st=%0d hs=%02h gs=%04h ty=%02h ",
								status, computed_header_sum, computed_global_sum, cart_type_code,
								"rb=%0d mb=%0d rv=%0b mv=%0b",
								rom_banks, ram_banks, rom_code_valid, ram_code_valid);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_byte(rom_byte, byte_address, last_byte);
			fail_count <= mismatches;
			pending_count <= reports_due.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the ROM image header validator testbench: clock, reset, image stimulus and verdict.
module tb_top;

	localparam int unsigned AW = 23;
	localparam int unsigned ITEM_TARGET = 1150;
	localparam int unsigned IMAGE_TARGET = 48;

	// Offsets of header words from the first header word of an image
	localparam int OFS_TYPE    = int'(rihv_pkg::POS_TYPE - rihv_pkg::HDR_FIRST);
	localparam int OFS_ROMSZ   = int'(rihv_pkg::POS_ROMSZ - rihv_pkg::HDR_FIRST);
	localparam int OFS_RAMSZ   = int'(rihv_pkg::POS_RAMSZ - rihv_pkg::HDR_FIRST);
	localparam int OFS_HDR_END = int'(rihv_pkg::HDR_LAST - rihv_pkg::HDR_FIRST);
	localparam int OFS_HSUM    = int'(rihv_pkg::POS_HSUM - rihv_pkg::HDR_FIRST);
	localparam int OFS_GSUM_HI = int'(rihv_pkg::POS_GSUM_HI - rihv_pkg::HDR_FIRST);
	localparam int OFS_GSUM_LO = int'(rihv_pkg::POS_GSUM_LO - rihv_pkg::HDR_FIRST);

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [7:0]               rom_byte = '0;
	logic [AW-1:0]            byte_address = '0;
	logic                     last_byte = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               status;
	logic [7:0]               computed_header_sum;
	logic [15:0]              computed_global_sum;
	logic [7:0]               cart_type_code;
	logic [rihv_pkg::ROM_BANK_BITS-1:0] rom_banks;
	logic [rihv_pkg::RAM_BANK_BITS-1:0] ram_banks;
	logic                     rom_code_valid;
	logic                     ram_code_valid;
	int                       check_failures;
	int                       results_pending;

	int tx_idle_pct = 13;
	int rx_idle_pct = 67;
	int items_sent = 0;

	// Image under construction: one word per entry
	logic [7:0]    img_data[$];
	logic [AW-1:0] img_addr[$];

	always #5 clk = ~clk;

	rom_image_header_validator #(.ADDR_BITS(AW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rom_byte(rom_byte), .byte_address(byte_address), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .computed_header_sum(computed_header_sum),
		.computed_global_sum(computed_global_sum), .cart_type_code(cart_type_code),
		.rom_banks(rom_banks), .ram_banks(ram_banks),
		.rom_code_valid(rom_code_valid), .ram_code_valid(ram_code_valid)
	);

	rihv_checker #(.AW(AW)) u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rom_byte(rom_byte), .byte_address(byte_address), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .computed_header_sum(computed_header_sum),
		.computed_global_sum(computed_global_sum), .cart_type_code(cart_type_code),
		.rom_banks(rom_banks), .ram_banks(ram_banks),
		.rom_code_valid(rom_code_valid), .ram_code_valid(ram_code_valid),
		.fail_count(check_failures), .pending_count(results_pending)
	);

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Offer one word, with random idle cycles first, and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic [AW-1:0] a, input logic l);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rom_byte <= b;
		byte_address <= a;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Hold off the sender until every owed status word has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	// Address outside the header block
	function automatic logic [AW-1:0] rand_plain_addr();
		if ($urandom_range(1))
			return AW'($urandom_range(32'h133, 0));
		return AW'($urandom_range(32'h7FFFFF, 32'h150));
	endfunction

	initial begin
		int            n_pre;
		int            n_suf;
		int            hdr_base;
		int            pos;
		int            phase;
		int            images;
		logic [7:0]    hs;
		logic [15:0]   gs;
		logic [7:0]    tmp_b;
		logic [AW-1:0] tmp_a;
		phase = 0;
		images = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, the end and special ROM size codes, every RAM size code, type, repeated capture
		send_byte(8'h00, '0, 1'b0);
		send_byte(8'hFF, '1, 1'b1);
		send_byte(8'h00, rihv_pkg::POS_ROMSZ, 1'b1);
		send_byte(rihv_pkg::ROM_CODE_SHIFT_MAX, rihv_pkg::POS_ROMSZ, 1'b1);
		send_byte(rihv_pkg::ROM_CODE_72, rihv_pkg::POS_ROMSZ, 1'b1);
		send_byte(rihv_pkg::ROM_CODE_80, rihv_pkg::POS_ROMSZ, 1'b1);
		send_byte(rihv_pkg::ROM_CODE_96, rihv_pkg::POS_ROMSZ, 1'b1);
		send_byte(8'h09, rihv_pkg::POS_ROMSZ, 1'b1);
		send_byte(8'hFF, rihv_pkg::POS_ROMSZ, 1'b1);
		send_byte(rihv_pkg::RAM_CODE_NONE, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(rihv_pkg::RAM_CODE_2K, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(rihv_pkg::RAM_CODE_8K, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(rihv_pkg::RAM_CODE_32K, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(rihv_pkg::RAM_CODE_128K, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(rihv_pkg::RAM_CODE_64K, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(8'h06, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(8'hFF, rihv_pkg::POS_RAMSZ, 1'b1);
		send_byte(8'hFF, rihv_pkg::POS_TYPE, 1'b1);
		send_byte(rihv_pkg::TYPE_ROM_ONLY, rihv_pkg::POS_TYPE, 1'b1);
		send_byte(8'hAA, rihv_pkg::POS_HSUM, 1'b0);
		send_byte(8'h55, rihv_pkg::POS_HSUM, 1'b1);
		send_byte(8'h12, rihv_pkg::POS_GSUM_HI, 1'b0);
		send_byte(8'h34, rihv_pkg::POS_GSUM_LO, 1'b1);

		// Random images, idle mix changing by phase
		while (items_sent < ITEM_TARGET || images < IMAGE_TARGET) begin
			if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
				drain_results();
				phase = 1;
				tx_idle_pct = 67;
				rx_idle_pct = 13;
			end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
				drain_results();
				phase = 2;
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			img_data.delete();
			img_addr.delete();
			if ($urandom_range(99) < 70) begin
				// well-formed header with random content and consistent checksums
				n_pre = $urandom_range(6);
				repeat (n_pre) begin
					img_addr.push_back(rand_plain_addr());
					img_data.push_back(8'($urandom));
				end
				hdr_base = img_data.size();
				for (int a = rihv_pkg::HDR_FIRST; a <= rihv_pkg::POS_GSUM_LO; a++) begin
					img_addr.push_back(AW'(a));
					img_data.push_back(8'($urandom));
				end
				if ($urandom_range(99) < 85)
					img_data[hdr_base + OFS_TYPE] = rihv_pkg::TYPE_ROM_ONLY;
				if ($urandom_range(99) < 75)
					img_data[hdr_base + OFS_ROMSZ] = $urandom_range(1) ?
						8'($urandom_range(rihv_pkg::ROM_CODE_SHIFT_MAX)) :
						8'($urandom_range(rihv_pkg::ROM_CODE_96, rihv_pkg::ROM_CODE_72));
				if ($urandom_range(99) < 75)
					img_data[hdr_base + OFS_RAMSZ] =
						8'($urandom_range(rihv_pkg::RAM_CODE_64K));
				hs = '0;
				for (int k = hdr_base; k <= hdr_base + OFS_HDR_END; k++)
					hs = hs - img_data[k] - 8'd1;
				img_data[hdr_base + OFS_HSUM] = hs;
				n_suf = $urandom_range(6);
				repeat (n_suf) begin
					img_addr.push_back(rand_plain_addr());
					img_data.push_back(8'($urandom));
				end
				gs = '0;
				foreach (img_data[k])
					if (k != hdr_base + OFS_GSUM_HI && k != hdr_base + OFS_GSUM_LO)
						gs = gs + 16'(img_data[k]);
				img_data[hdr_base + OFS_GSUM_HI] = gs[15:8];
				img_data[hdr_base + OFS_GSUM_LO] = gs[7:0];
				// break some images: a flipped bit or a repeated word
				if ($urandom_range(99) < 25) begin
					pos = $urandom_range(img_data.size() - 1);
					if ($urandom_range(1)) begin
						img_data[pos] = img_data[pos] ^ 8'(1 << $urandom_range(7));
					end else begin
						img_data.insert(pos, img_data[pos]);
						img_addr.insert(pos, img_addr[pos]);
					end
				end
				// sometimes a randomly chosen word, header or not, comes last
				if ($urandom_range(99) < 30) begin
					pos = $urandom_range(img_data.size() - 1);
					tmp_b = img_data[pos];
					tmp_a = img_addr[pos];
					img_data[pos] = img_data[img_data.size() - 1];
					img_addr[pos] = img_addr[img_addr.size() - 1];
					img_data[img_data.size() - 1] = tmp_b;
					img_addr[img_addr.size() - 1] = tmp_a;
				end
			end else begin
				// short noise image, mostly missing the header
				repeat ($urandom_range(6, 1)) begin
					img_addr.push_back($urandom_range(1) ? AW'($urandom) :
						AW'($urandom_range(32'h150, 32'h130)));
					img_data.push_back(8'($urandom));
				end
			end
			foreach (img_data[k])
				send_byte(img_data[k], img_addr[k], k == img_data.size() - 1);
			images++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (check_failures == 0 && results_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
design/rihv_pkg.sv
design/rom_image_header_validator.sv
tb/rihv_checker.sv
tb/tb_top.sv
